### src/ssfl_pkg.sv
// Shared types, register codes and the case folding function of the substring search.
`timescale 1ns / 1ps

package ssfl_pkg;

  // Number of 64-bit pattern registers and the bytes they hold.
  localparam int PatternWords = 4;
  localparam int PatternBytes = 8 * PatternWords;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_BYTES_0 = 3'd1,
    CFG_PATTERN_BYTES_1 = 3'd2,
    CFG_PATTERN_BYTES_2 = 3'd3,
    CFG_PATTERN_BYTES_3 = 3'd4,
    CFG_IGNORE_CASE = 3'd5,
    CFG_MATCH_MODE = 3'd6
  } ssfl_cfg_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_STARTS_WITH = 2'd1,
    MODE_ENDS_WITH = 2'd2,
    MODE_CONTAINS = 2'd3
  } ssfl_mode_e;

  // What every cell of the chain sees in a cycle.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       ignore_case;
    logic       advance;
    logic       clear;
  } ssfl_bcast_t;

  // Folds ASCII A-Z to lower case when enabled.
  function automatic logic [7:0] ssfl_fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[8'h41 : 8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### src/substring_search_first_last.sv
// Top level of the streaming substring search with first and last match positions.
`timescale 1ns / 1ps

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  input    | in        | in_valid_i / in_stall_o | text_byte_i, last_byte_i
//  result   | out       | out_valid_o / out_stall_i | mode_verdict_o, first_found_o,
//           |           |                        | first_position_o, last_position_o,
//           |           |                        | text_length_o, too_long_o
//  config   | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One text byte is taken every cycle that the input does not stall; the chain of match cells
// and the position update finish within the cycle of acceptance.
// A result appears on the output register the cycle after the final byte is accepted.
// Reset clears the stream state and sets the pattern length to one, other config to zero.
// The input stalls only while a result is held in the output register and the output
// side stalls; a freed output register takes the next result in the same cycle.

module substring_search_first_last #(
  parameter int PATTERN_MAX = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  ssfl_pkg::ssfl_cfg_e      cfg_index_i,
  input  logic [63:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               text_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     mode_verdict_o,
  output logic                     first_found_o,
  output logic [POSITION_BITS-1:0] first_position_o,
  output logic [POSITION_BITS-1:0] last_position_o,
  output logic [POSITION_BITS-1:0] text_length_o,
  output logic                     too_long_o
);
  import ssfl_pkg::*;

  localparam int LenW = $clog2(PATTERN_MAX + 1);
  localparam logic [POSITION_BITS-1:0] PosLimit = {POSITION_BITS{1'b1}};

  // Configuration registers.
  logic [5:0]                       pat_len_q;
  logic [PatternWords-1:0][63:0]    pat_words_q;
  logic                             ignore_case_q;
  ssfl_mode_e                       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q     <= 6'd1;
      pat_words_q   <= '0;
      ignore_case_q <= 1'b0;
      mode_q        <= MODE_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH:  pat_len_q      <= cfg_data_i[5:0];
        CFG_PATTERN_BYTES_0: pat_words_q[0] <= cfg_data_i;
        CFG_PATTERN_BYTES_1: pat_words_q[1] <= cfg_data_i;
        CFG_PATTERN_BYTES_2: pat_words_q[2] <= cfg_data_i;
        CFG_PATTERN_BYTES_3: pat_words_q[3] <= cfg_data_i;
        CFG_IGNORE_CASE:     ignore_case_q  <= cfg_data_i[0];
        CFG_MATCH_MODE:      mode_q         <= ssfl_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // The length in use: zero counts as one, and anything above the chain length is clipped.
  logic [6:0]            len_ext;
  logic [6:0]            len_clip;
  logic [LenW-1:0]       used_len;
  logic [POSITION_BITS-1:0] used_len_pos;

  always_comb begin
    len_ext = {1'b0, pat_len_q};
    if (len_ext == 7'd0) begin
      len_clip = 7'd1;
    end else if (len_ext > 7'(PATTERN_MAX)) begin
      len_clip = 7'(PATTERN_MAX);
    end else begin
      len_clip = len_ext;
    end
    used_len     = LenW'(len_clip);
    used_len_pos = POSITION_BITS'(used_len);
  end

  // Handshake and the broadcast to the cells.
  logic        out_valid_q;
  logic        in_accept;
  logic        load_result;
  ssfl_bcast_t bcast;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign load_result = in_accept && last_byte_i;

  assign bcast.text_byte   = text_byte_i;
  assign bcast.ignore_case = ignore_case_q;
  assign bcast.advance     = in_accept;
  assign bcast.clear       = last_byte_i;

  // The chain: cell j carries the match of pattern bytes 0 through j ending at the
  // latest byte. The cell at the pattern length minus one reports a full occurrence.
  logic [PATTERN_MAX-1:0] match_d;
  logic [PATTERN_MAX-1:0] match_q;
  logic [PATTERN_MAX-1:0] tap;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [7:0] pat_byte;
    logic       prev_match;

    if (j < PatternBytes) begin : g_pat
      assign pat_byte = pat_words_q[j / 8][(j % 8) * 8 +: 8];
    end else begin : g_zero
      // Pattern bytes past the register file read as zero.
      assign pat_byte = 8'h00;
    end

    if (j == 0) begin : g_head
      assign prev_match = 1'b1;
    end else begin : g_link
      assign prev_match = match_q[j-1];
    end

    assign tap[j] = (used_len == LenW'(j + 1));

    ssfl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bcast_i      (bcast),
      .pat_byte_i   (pat_byte),
      .prev_match_i (prev_match),
      .match_d_o    (match_d[j]),
      .match_q_o    (match_q[j])
    );
  end

  logic hit;
  assign hit = |(match_d & tap);

  // Stream state: byte count, overflow and the recorded occurrences.
  logic [POSITION_BITS-1:0] count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic                     have_q, have_d;
  logic [POSITION_BITS-1:0] earliest_q, earliest_d;
  logic [POSITION_BITS-1:0] latest_q, latest_d;
  logic                     sat;
  logic                     record;
  logic [POSITION_BITS-1:0] start_pos;

  always_comb begin
    sat       = (count_q == PosLimit);
    count_d   = sat ? count_q : count_q + 1'b1;
    ovf_d     = ovf_q || sat;
    // Once the counter is saturated no further occurrence is recorded.
    record    = hit && !sat;
    start_pos = count_d - used_len_pos;
    have_d    = have_q || record;
    earliest_d = (record && !have_q) ? start_pos : earliest_q;
    latest_d   = record ? start_pos : latest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      have_q     <= 1'b0;
      earliest_q <= '0;
      latest_q   <= '0;
    end else if (in_accept) begin
      if (last_byte_i) begin
        // The text ends here, so the next byte starts a fresh stream.
        count_q    <= '0;
        ovf_q      <= 1'b0;
        have_q     <= 1'b0;
        earliest_q <= '0;
        latest_q   <= '0;
      end else begin
        count_q    <= count_d;
        ovf_q      <= ovf_d;
        have_q     <= have_d;
        earliest_q <= earliest_d;
        latest_q   <= latest_d;
      end
    end
  end

  // Verdict of the selected mode, judged on the state that includes the final byte.
  logic verdict;

  always_comb begin
    case (mode_q)
      MODE_STARTS_WITH: verdict = have_d && (earliest_d == '0);
      MODE_ENDS_WITH:   verdict = have_d && (count_d >= used_len_pos) &&
                                  (latest_d == count_d - used_len_pos);
      MODE_CONTAINS:    verdict = have_d;
      default:          verdict = 1'b0;
    endcase
  end

  // Output register.
  logic                     verdict_q;
  logic                     found_q;
  logic [POSITION_BITS-1:0] first_pos_q;
  logic [POSITION_BITS-1:0] last_pos_q;
  logic [POSITION_BITS-1:0] length_q;
  logic                     too_long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      verdict_q   <= verdict;
      found_q     <= have_d;
      first_pos_q <= have_d ? earliest_d : '0;
      last_pos_q  <= have_d ? latest_d : '0;
      length_q    <= count_d;
      too_long_q  <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_verdict_o   = verdict_q;
  assign first_found_o    = found_q;
  assign first_position_o = first_pos_q;
  assign last_position_o  = last_pos_q;
  assign text_length_o    = length_q;
  assign too_long_o       = too_long_q;

  // A final byte that is accepted always leaves a result in the output register.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> out_valid_o)
    else $error("final byte accepted without a result");

  // An overflowed text reports a saturated length.
  a_too_long_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (text_length_o == PosLimit))
    else $error("overflow flag without saturated length");

  // Without an occurrence both positions read as zero.
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !first_found_o) |-> (first_position_o == '0 && last_position_o == '0))
    else $error("positions set without an occurrence");

  // The earliest occurrence never starts after the latest one.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_found_o) |-> (first_position_o <= last_position_o))
    else $error("first position after last position");

endmodule

### src/ssfl_cell.sv
// One cell of the match chain: holds whether the pattern prefix up to this cell ends here.
`timescale 1ns / 1ps

module ssfl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssfl_pkg::ssfl_bcast_t bcast_i,
  input  logic [7:0]         pat_byte_i,
  input  logic               prev_match_i,
  output logic               match_d_o,
  output logic               match_q_o
);
  import ssfl_pkg::*;

  logic match_d;
  logic match_q;

  // The prefix through this cell matches when the previous prefix matched one byte ago
  // and the new byte equals this cell's pattern byte.
  assign match_d = prev_match_i &&
                   (ssfl_fold(pat_byte_i, bcast_i.ignore_case) ==
                    ssfl_fold(bcast_i.text_byte, bcast_i.ignore_case));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (bcast_i.advance) begin
      match_q <= bcast_i.clear ? 1'b0 : match_d;
    end
  end

  assign match_d_o = match_d;
  assign match_q_o = match_q;

endmodule
